/* hdl/lottery_scheduler_with_boosts_assert.svh */
// ----------------------------------------------------------------------------
// Lottery scheduler assertion macros
// Short forms for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LOTTERY_SCHEDULER_WITH_BOOSTS_ASSERT_SVH
`define LOTTERY_SCHEDULER_WITH_BOOSTS_ASSERT_SVH

// ante true in a cycle requires cons in the same cycle
`define LSB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante true in a cycle requires cons in the following cycle
`define LSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lsb_pkg.sv */
// ----------------------------------------------------------------------------
// Lottery scheduler package
// Shared codes, table entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lsb_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int RND_W     = 31;
  localparam int DIV_STEPS = 31;

  localparam logic [RND_W-1:0] LCG_MUL = 31'd1103515245;
  localparam logic [RND_W-1:0] LCG_ADD = 31'd12345;

  // slot state codes
  localparam logic [2:0] SS_EMBRYO   = 3'd1;
  localparam logic [2:0] SS_SLEEPING = 3'd2;
  localparam logic [2:0] SS_RUNNABLE = 3'd3;
  localparam logic [2:0] SS_RUNNING  = 3'd4;
  localparam logic [2:0] SS_MAX      = 3'd5;

  typedef enum logic [2:0] {
    CMD_CREATE      = 3'd0,
    CMD_SET_STATE   = 3'd1,
    CMD_SET_TICKETS = 3'd2,
    CMD_DRAW        = 3'd3,
    CMD_READ        = 3'd4,
    CMD_REMOVE      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NO_TICKETS     = 3'd1,
    ST_BAD_TICKETS    = 3'd2,
    ST_PID_MISSING    = 3'd3,
    ST_PARENT_MISSING = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    WM_SCAN = 2'd0,
    WM_SUM  = 2'd1,
    WM_DRAW = 2'd2
  } walk_mode_t;

  typedef struct packed {
    logic [2:0]  state;
    logic        in_use;
    logic [15:0] pid;
    logic [15:0] tickets;
    logic [31:0] runs;
    logic [15:0] boosts;
  } entry_t;

  typedef struct packed {
    logic       idle;
    logic       walk_start;
    walk_mode_t mode;
    logic       rd_slot;
    logic       apply;
    logic       lcg_mul;
    logic       lcg_add;
    logic       div_start;
    logic       finish;
    status_t    status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       slot_ok;
    logic       ns_ok;
    logic       tk_zero;
    logic       ppid_zero;
    logic       walk_busy;
    logic       found;
    logic       sum_zero;
    logic       div_busy;
  } dp_stat_t;

endpackage

/* hdl/lsb_div.sv */
// ----------------------------------------------------------------------------
// Lottery scheduler remainder unit
// Restoring division, one quotient bit per cycle; keeps only the remainder.
// ----------------------------------------------------------------------------
module lsb_div #(
  parameter int SUM_W = 23
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [lsb_pkg::RND_W-1:0] dividend,
  input  logic [SUM_W-1:0]        divisor,
  output logic                    busy,
  output logic [SUM_W-1:0]        rem
);
  import lsb_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0] cnt;
  logic [RND_W-1:0] quo;
  logic [SUM_W-1:0] dvs;
  logic [SUM_W:0]   trial;

  assign trial = {rem, quo[RND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(DIV_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      // subtract when the shifted remainder reaches the divisor
      if (trial >= {1'b0, dvs}) begin
        rem <= SUM_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[SUM_W-1:0];
      end
      quo <= quo << 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

/* hdl/lsb_dp.sv */
// ----------------------------------------------------------------------------
// Lottery scheduler datapath
// Slot table memory, walk engine, generator, remainder unit and result regs.
// ----------------------------------------------------------------------------
module lsb_dp #(
  parameter int SLOTS = lsb_pkg::SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lsb_pkg::ctrl_cmd_t    cmd,
  output lsb_pkg::dp_stat_t     st,
  input  logic [2:0]            command,
  input  logic [5:0]            slot,
  input  logic [15:0]           pid,
  input  logic [15:0]           parent_pid,
  input  logic [15:0]           tickets,
  input  logic [2:0]            new_state,
  input  logic                  seed_load,
  input  logic [lsb_pkg::RND_W-1:0] seed,
  output logic                  done,
  output logic [2:0]            status,
  output logic                  winner_valid,
  output logic [5:0]            winner_slot,
  output logic [15:0]           read_tickets,
  output logic [31:0]           read_runs,
  output logic [15:0]           read_boosts,
  output logic [2:0]            read_state,
  output logic                  read_in_use
);
  import lsb_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int SUM_W = 17 + IDX_W;

  // latched item
  logic [2:0]  l_cmd;
  logic [5:0]  l_slot;
  logic [15:0] l_pid;
  logic [15:0] l_ppid;
  logic [15:0] l_tk;
  logic [2:0]  l_ns;

  logic             slot_ok;
  logic [IDX_W-1:0] slot_addr;
  logic [15:0]      key;

  // table memory with per-entry valid bits
  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] vld;
  entry_t           rdata;
  logic             rvld;
  entry_t           e;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  // walk engine
  logic             wact;
  logic [CNT_W-1:0] widx;
  logic             pv;
  logic [IDX_W-1:0] paddr;
  walk_mode_t       mode;
  logic [SUM_W-1:0] acc;
  logic             found;
  logic             won;
  logic [IDX_W-1:0] win_idx;
  logic [IDX_W-1:0] match_idx;
  logic             spend;
  entry_t           cap;

  // draw arithmetic
  logic [SUM_W-1:0] t_ext;
  logic [SUM_W-1:0] add;
  logic [SUM_W-1:0] acc_sum;
  logic             hit;
  entry_t           upd;

  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] prod;
  logic             div_busy;
  logic [SUM_W-1:0] draw_val;

  always_ff @(posedge clk) begin
    if (cmd.idle) begin
      l_cmd  <= command;
      l_slot <= slot;
      l_pid  <= pid;
      l_ppid <= parent_pid;
      l_tk   <= tickets;
      l_ns   <= new_state;
    end
  end

  assign slot_ok   = int'(l_slot) < SLOTS;
  assign slot_addr = IDX_W'(l_slot);
  assign key       = (l_cmd == CMD_CREATE) ? l_ppid : l_pid;

  assign st.cmd       = l_cmd;
  assign st.slot_ok   = slot_ok;
  assign st.ns_ok     = l_ns <= SS_MAX;
  assign st.tk_zero   = l_tk == 16'd0;
  assign st.ppid_zero = l_ppid == 16'd0;
  assign st.walk_busy = wact | pv;
  assign st.found     = found;
  assign st.sum_zero  = acc == '0;
  assign st.div_busy  = div_busy;

  assign raddr = wact ? widx[IDX_W-1:0] : slot_addr;
  assign e     = rvld ? rdata : '0;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    rvld  <= vld[raddr];
  end

  always_comb begin
    t_ext   = SUM_W'(e.tickets);
    add     = (e.boosts != 16'd0) ? (t_ext << 1) : t_ext;
    acc_sum = acc + add;
    hit     = 1'b0;
    upd     = e;
    if (e.state == SS_SLEEPING) begin
      if (e.boosts != 16'hffff) begin
        upd.boosts = e.boosts + 16'd1;
      end
    end else if (e.state == SS_RUNNABLE) begin
      if (e.boosts != 16'd0) begin
        upd.boosts = e.boosts - 16'd1;
      end
      hit = !won && (acc_sum > draw_val);
      if (hit) begin
        upd.runs  = e.runs + 32'd1;
        upd.state = SS_RUNNING;
      end
    end
  end

  // single write port: draw walk or command apply
  always_comb begin
    we    = 1'b0;
    waddr = slot_addr;
    wdata = cap;
    if (pv && mode == WM_DRAW &&
        (e.state == SS_SLEEPING || e.state == SS_RUNNABLE)) begin
      we    = 1'b1;
      waddr = paddr;
      wdata = upd;
    end else if (cmd.apply) begin
      case (l_cmd)
        CMD_CREATE: begin
          we            = slot_ok;
          wdata         = '0;
          wdata.state   = SS_EMBRYO;
          wdata.in_use  = 1'b1;
          wdata.pid     = l_pid;
          wdata.tickets = (l_ppid == 16'd0) ? 16'd1 : cap.tickets;
        end
        CMD_SET_STATE: begin
          we          = 1'b1;
          wdata.state = l_ns;
        end
        CMD_SET_TICKETS: begin
          we            = 1'b1;
          waddr         = match_idx;
          wdata.tickets = l_tk;
        end
        CMD_REMOVE: begin
          we           = 1'b1;
          waddr        = match_idx;
          wdata.in_use = 1'b0;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wact  <= 1'b0;
      pv    <= 1'b0;
      spend <= 1'b0;
    end else begin
      spend <= cmd.rd_slot;
      pv    <= wact;
      if (cmd.walk_start) begin
        wact <= 1'b1;
      end else if (wact && widx == CNT_W'(SLOTS - 1)) begin
        wact <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      widx  <= '0;
      mode  <= cmd.mode;
      acc   <= '0;
      found <= 1'b0;
      won   <= 1'b0;
    end else begin
      if (wact) begin
        widx  <= widx + 1'b1;
        paddr <= widx[IDX_W-1:0];
      end
      if (pv) begin
        case (mode)
          WM_SCAN: begin
            if (!found && e.in_use && e.pid == key) begin
              found     <= 1'b1;
              match_idx <= paddr;
              cap       <= e;
            end
          end
          WM_SUM: begin
            if (e.state == SS_RUNNABLE) begin
              acc <= acc_sum;
            end
          end
          WM_DRAW: begin
            if (e.state == SS_RUNNABLE) begin
              acc <= acc_sum;
              if (hit) begin
                won     <= 1'b1;
                win_idx <= paddr;
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (spend) begin
      cap <= e;
    end
  end

  // generator: multiply, then add; the 31-bit width does the masking
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (seed_load) begin
      rnd <= seed;
    end else if (cmd.lcg_add) begin
      rnd <= prod + LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lcg_mul) begin
      prod <= RND_W'(rnd * LCG_MUL);
    end
  end

  lsb_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rnd),
    .divisor  (acc),
    .busy     (div_busy),
    .rem      (draw_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= cmd.status;
      winner_valid <= (l_cmd == CMD_DRAW) && won;
      winner_slot  <= ((l_cmd == CMD_DRAW) && won) ? 6'(win_idx) : 6'd0;
      if (l_cmd == CMD_READ && slot_ok) begin
        read_tickets <= cap.tickets;
        read_runs    <= cap.runs;
        read_boosts  <= cap.boosts;
        read_state   <= cap.state;
        read_in_use  <= cap.in_use;
      end else begin
        read_tickets <= '0;
        read_runs    <= '0;
        read_boosts  <= '0;
        read_state   <= '0;
        read_in_use  <= 1'b0;
      end
    end
  end

endmodule

/* hdl/lsb_ctrl.sv */
// ----------------------------------------------------------------------------
// Lottery scheduler controller
// Sequences each command through the datapath; commands are registered.
// ----------------------------------------------------------------------------
module lsb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lsb_pkg::dp_stat_t  st,
  output lsb_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import lsb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCANW,
    S_RD,
    S_RDW,
    S_APPLY,
    S_SUMW,
    S_MUL,
    S_ADD,
    S_DIVW,
    S_DRAWW,
    S_FIN
  } state_t;

  state_t    state;
  state_t    state_next;
  ctrl_cmd_t cmd_next;

  always_comb begin
    state_next = state;
    cmd_next   = '0;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.cmd)
          CMD_CREATE: begin
            if (st.ppid_zero) begin
              state_next = S_APPLY;
            end else begin
              state_next          = S_SCANW;
              cmd_next.walk_start = 1'b1;
              cmd_next.mode       = WM_SCAN;
            end
          end
          CMD_SET_STATE: begin
            state_next = (st.slot_ok && st.ns_ok) ? S_RD : S_FIN;
          end
          CMD_SET_TICKETS: begin
            if (st.tk_zero) begin
              state_next      = S_FIN;
              cmd_next.status = ST_BAD_TICKETS;
            end else begin
              state_next          = S_SCANW;
              cmd_next.walk_start = 1'b1;
              cmd_next.mode       = WM_SCAN;
            end
          end
          CMD_DRAW: begin
            state_next          = S_SUMW;
            cmd_next.walk_start = 1'b1;
            cmd_next.mode       = WM_SUM;
          end
          CMD_READ: begin
            state_next = st.slot_ok ? S_RD : S_FIN;
          end
          CMD_REMOVE: begin
            state_next          = S_SCANW;
            cmd_next.walk_start = 1'b1;
            cmd_next.mode       = WM_SCAN;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_SCANW: begin
        // hold until the walk has started and drained
        if (!cmd.walk_start && !st.walk_busy) begin
          if (st.found) begin
            state_next = S_APPLY;
          end else begin
            state_next      = S_FIN;
            cmd_next.status = (st.cmd == CMD_CREATE) ? ST_PARENT_MISSING
                                                     : ST_PID_MISSING;
          end
        end
      end
      S_RD:    state_next = S_RDW;
      S_RDW:   state_next = (st.cmd == CMD_READ) ? S_FIN : S_APPLY;
      S_APPLY: state_next = S_FIN;
      S_SUMW: begin
        if (!cmd.walk_start && !st.walk_busy) begin
          if (st.sum_zero) begin
            state_next      = S_FIN;
            cmd_next.status = ST_NO_TICKETS;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: state_next = S_ADD;
      S_ADD: state_next = S_DIVW;
      S_DIVW: begin
        if (!cmd.div_start && !st.div_busy) begin
          state_next          = S_DRAWW;
          cmd_next.walk_start = 1'b1;
          cmd_next.mode       = WM_DRAW;
        end
      end
      S_DRAWW: begin
        if (!cmd.walk_start && !st.walk_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase

    // one-cycle commands tied to the state being entered
    if (state_next != state) begin
      case (state_next)
        S_RD:    cmd_next.rd_slot   = 1'b1;
        S_APPLY: cmd_next.apply     = 1'b1;
        S_MUL:   cmd_next.lcg_mul   = 1'b1;
        S_ADD:   cmd_next.lcg_add   = 1'b1;
        S_DIVW:  cmd_next.div_start = 1'b1;
        S_FIN:   cmd_next.finish    = 1'b1;
        default: ;
      endcase
    end
    cmd_next.idle = (state_next == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= '{idle: 1'b1, mode: WM_SCAN, status: ST_OK, default: 1'b0};
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

/* hdl/lottery_scheduler_with_boosts.sv */
// ----------------------------------------------------------------------------
// Lottery scheduler with sleep boosts
// Slot table of SLOTS entries with create, state, ticket, remove, read and
// draw commands; draws pick a runnable slot weighted by tickets, doubled for boosted slots.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with the command fields while busy is low; the item transfers
//   at that edge and busy rises. One result follows per item: done is high
//   for exactly one cycle with status, winner and read fields, and busy is
//   low again in that cycle, so a new start may be given there.
//   Read, set state and create with no parent do not walk the table; create
//   with a parent, set tickets (with nonzero tickets) and remove walk the
//   table once. A draw walks the table twice and runs a 31-step remainder
//   unit; a draw with no runnable tickets walks the table once.
//   The table sits in one memory with a single read and a single write port,
//   so each walk reads one slot per cycle.
//   The seed channel (cfg_valid/cfg_ready/cfg_data) loads the generator; it
//   is ready whenever the block is idle.
//   Reset clears the table through per-slot valid bits and zeros the
//   generator; the block is ready in the first cycle after reset.
//   Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "lottery_scheduler_with_boosts_assert.svh"

module lottery_scheduler_with_boosts #(
  parameter int SLOTS = lsb_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                command,
  input  logic [5:0]                slot,
  input  logic [15:0]               pid,
  input  logic [15:0]               parent_pid,
  input  logic [15:0]               tickets,
  input  logic [2:0]                new_state,
  output logic                      done,
  output logic [2:0]                status,
  output logic                      winner_valid,
  output logic [5:0]                winner_slot,
  output logic [15:0]               read_tickets,
  output logic [31:0]               read_runs,
  output logic [15:0]               read_boosts,
  output logic [2:0]                read_state,
  output logic                      read_in_use,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lsb_pkg::RND_W-1:0] cfg_data
);
  import lsb_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  assign cfg_ready = !busy;

  lsb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  lsb_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .command      (command),
    .slot         (slot),
    .pid          (pid),
    .parent_pid   (parent_pid),
    .tickets      (tickets),
    .new_state    (new_state),
    .seed_load    (cfg_valid && cfg_ready),
    .seed         (cfg_data),
    .done         (done),
    .status       (status),
    .winner_valid (winner_valid),
    .winner_slot  (winner_slot),
    .read_tickets (read_tickets),
    .read_runs    (read_runs),
    .read_boosts  (read_boosts),
    .read_state   (read_state),
    .read_in_use  (read_in_use)
  );

  `LSB_ASSERT_SAME(a_done_idle, done, !busy, "result while busy")
  `LSB_ASSERT_SAME(a_win_ok, done && winner_valid, status == ST_OK, "winner with error status")
  `LSB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `LSB_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery scheduler testbench
// Drives create, state, ticket, remove, read and draw commands with random
// gaps and seed writes, predicts each result from a table copy held here, and
// compares every done strobe field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import lsb_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [2:0] SS_UNUSED   = 3'd0;
  localparam logic [2:0] SS_ZOMBIE   = 3'd5;
  localparam int         NSLOT       = 64;

  typedef struct {
    logic [2:0]  status;
    logic        win_valid;
    logic [5:0]  win_slot;
    logic [15:0] rd_tickets;
    logic [31:0] rd_runs;
    logic [15:0] rd_boosts;
    logic [2:0]  rd_state;
    logic        rd_in_use;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  command = '0;
  logic [5:0]  slot = '0;
  logic [15:0] pid = '0;
  logic [15:0] parent_pid = '0;
  logic [15:0] tickets = '0;
  logic [2:0]  new_state = '0;
  logic        done;
  logic [2:0]  status;
  logic        winner_valid;
  logic [5:0]  winner_slot;
  logic [15:0] read_tickets;
  logic [31:0] read_runs;
  logic [15:0] read_boosts;
  logic [2:0]  read_state;
  logic        read_in_use;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = '0;

  // shadow of the slot table and generator
  logic [2:0]  tbl_state  [NSLOT];
  logic        tbl_in_use [NSLOT];
  logic [15:0] tbl_pid    [NSLOT];
  logic [15:0] tbl_tickets[NSLOT];
  logic [31:0] tbl_runs   [NSLOT];
  logic [15:0] tbl_boosts [NSLOT];
  logic [30:0] lcg_state;

  sched_result_t pending_results[$];
  int  fail_count = 0;
  bit  burst = 1'b0;

  lottery_scheduler_with_boosts dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .slot(slot), .pid(pid), .parent_pid(parent_pid), .tickets(tickets),
    .new_state(new_state), .done(done), .status(status),
    .winner_valid(winner_valid), .winner_slot(winner_slot),
    .read_tickets(read_tickets), .read_runs(read_runs),
    .read_boosts(read_boosts), .read_state(read_state),
    .read_in_use(read_in_use), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int lookup_pid(input logic [15:0] p);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_in_use[i] && tbl_pid[i] == p) return i;
    return -1;
  endfunction

  function automatic sched_result_t schedule_step(input logic [2:0] c, input logic [5:0] s,
      input logic [15:0] p, input logic [15:0] pp, input logic [15:0] tk,
      input logic [2:0] ns);
    sched_result_t r;
    int idx;
    logic [15:0] inherit;
    logic [31:0] total;
    logic [31:0] acc;
    logic [31:0] pick;
    bit found;
    r = '{default: '0};
    case (c)
      CMD_CREATE: begin
        inherit = 16'd1;
        idx = 0;
        if (pp != 0) begin
          idx = lookup_pid(pp);
          if (idx >= 0) inherit = tbl_tickets[idx];
        end
        if (idx < 0) r.status = ST_PARENT_MISSING;
        else begin
          tbl_state[s] = SS_EMBRYO;
          tbl_in_use[s] = 1'b1;
          tbl_pid[s] = p;
          tbl_tickets[s] = inherit;
          tbl_runs[s] = '0;
          tbl_boosts[s] = '0;
        end
      end
      CMD_SET_STATE: if (ns <= SS_MAX) tbl_state[s] = ns;
      CMD_SET_TICKETS: begin
        idx = lookup_pid(p);
        if (tk == 0) r.status = ST_BAD_TICKETS;
        else if (idx < 0) r.status = ST_PID_MISSING;
        else tbl_tickets[idx] = tk;
      end
      CMD_DRAW: begin
        total = '0;
        for (int i = 0; i < NSLOT; i++)
          if (tbl_state[i] == SS_RUNNABLE)
            total += (tbl_boosts[i] != 0) ? 2 * tbl_tickets[i] : tbl_tickets[i];
        if (total == 0) r.status = ST_NO_TICKETS;
        else begin
          lcg_state = lcg_state * LCG_MUL + LCG_ADD;
          pick = {1'b0, lcg_state} % total;
          acc = '0;
          found = 1'b0;
          for (int i = 0; i < NSLOT; i++) begin
            if (tbl_state[i] == SS_SLEEPING) begin
              if (tbl_boosts[i] != 16'hffff) tbl_boosts[i]++;
            end else if (tbl_state[i] == SS_RUNNABLE) begin
              acc += tbl_tickets[i];
              if (tbl_boosts[i] != 0) begin
                acc += tbl_tickets[i];
                tbl_boosts[i]--;
              end
              if (!found && acc > pick) begin
                found = 1'b1;
                tbl_runs[i]++;
                tbl_state[i] = SS_RUNNING;
                r.win_valid = 1'b1;
                r.win_slot = 6'(i);
              end
            end
          end
        end
      end
      CMD_READ: begin
        r.rd_tickets = tbl_tickets[s];
        r.rd_runs = tbl_runs[s];
        r.rd_boosts = tbl_boosts[s];
        r.rd_state = tbl_state[s];
        r.rd_in_use = tbl_in_use[s];
      end
      CMD_REMOVE: begin
        idx = lookup_pid(p);
        if (idx < 0) r.status = ST_PID_MISSING;
        else tbl_in_use[idx] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one command; start stays high across back-to-back transfers
  task automatic issue_cmd(input logic [2:0] c, input logic [5:0] s, input logic [15:0] p,
      input logic [15:0] pp, input logic [15:0] tk, input logic [2:0] ns);
    int gap;
    command <= c;
    slot <= s;
    pid <= p;
    parent_pid <= pp;
    tickets <= tk;
    new_state <= ns;
    if (!start) start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(schedule_step(c, s, p, pp, tk, ns));
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    if (start) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [30:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    lcg_state = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no command outstanding");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", 32'(e.status), 32'(status));
        check_field("winner_valid", 32'(e.win_valid), 32'(winner_valid));
        check_field("winner_slot", 32'(e.win_slot), 32'(winner_slot));
        check_field("read_tickets", 32'(e.rd_tickets), 32'(read_tickets));
        check_field("read_runs", e.rd_runs, read_runs);
        check_field("read_boosts", 32'(e.rd_boosts), 32'(read_boosts));
        check_field("read_state", 32'(e.rd_state), 32'(read_state));
        check_field("read_in_use", 32'(e.rd_in_use), 32'(read_in_use));
      end
    end
  end

  task automatic test_create_and_read;
    issue_cmd(CMD_DRAW, 0, 0, 0, 0, 0);                // empty table
    issue_cmd(CMD_CREATE, 0, 16'd1, 16'd0, 0, 0);
    issue_cmd(CMD_CREATE, 6'd63, 16'hffff, 16'd1, 0, 0);
    issue_cmd(CMD_CREATE, 6'd5, 16'd7, 16'd99, 0, 0);   // parent missing
    issue_cmd(CMD_READ, 6'd63, 0, 0, 0, 0);
    issue_cmd(CMD_READ, 6'd5, 0, 0, 0, 0);
    issue_cmd(CMD_SPARE_6, 6'd63, 16'hffff, 16'hffff, 16'hffff, 3'd7);
    issue_cmd(CMD_SPARE_7, 0, 0, 0, 0, 0);
  endtask

  task automatic test_tickets_and_state;
    issue_cmd(CMD_SET_TICKETS, 0, 16'd1, 0, 16'd0, 0);     // zero rejected
    issue_cmd(CMD_SET_TICKETS, 0, 16'd4321, 0, 16'd5, 0);  // pid missing
    issue_cmd(CMD_SET_TICKETS, 0, 16'hffff, 0, 16'hffff, 0);
    issue_cmd(CMD_SET_TICKETS, 0, 16'd1, 0, 16'd3, 0);
    issue_cmd(CMD_SET_STATE, 0, 0, 0, 0, 3'd6);            // bad code ignored
    issue_cmd(CMD_SET_STATE, 0, 0, 0, 0, 3'd7);
    issue_cmd(CMD_SET_STATE, 0, 0, 0, 0, SS_RUNNABLE);
    issue_cmd(CMD_SET_STATE, 6'd63, 0, 0, 0, SS_RUNNABLE);
    issue_cmd(CMD_SET_STATE, 6'd5, 0, 0, 0, SS_SLEEPING);
  endtask

  task automatic test_draw_and_remove;
    issue_cmd(CMD_DRAW, 0, 0, 0, 0, 0);
    issue_cmd(CMD_DRAW, 0, 0, 0, 0, 0);
    issue_cmd(CMD_SET_STATE, 6'd5, 0, 0, 0, SS_RUNNABLE);  // now boosted
    issue_cmd(CMD_DRAW, 0, 0, 0, 0, 0);
    issue_cmd(CMD_REMOVE, 0, 16'hffff, 0, 0, 0);
    issue_cmd(CMD_REMOVE, 0, 16'hffff, 0, 0, 0);           // already gone
    issue_cmd(CMD_READ, 6'd63, 0, 0, 0, 0);
    issue_cmd(CMD_SET_STATE, 6'd1, 0, 0, 0, SS_ZOMBIE);
    issue_cmd(CMD_SET_STATE, 6'd2, 0, 0, 0, SS_UNUSED);
  endtask

  function automatic logic [15:0] pick_pid;
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
  endfunction

  task automatic test_random_mix(input int count);
    logic [2:0]  c;
    logic [5:0]  s;
    logic [15:0] pp;
    logic [15:0] tk;
    logic [2:0]  ns;
    int w;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n % 130 == 129) write_seed(31'($urandom));
      if (n == count / 2) drain();
      w = $urandom_range(0, 99);
      c = (w < 25) ? CMD_DRAW : (w < 47) ? CMD_SET_STATE : (w < 62) ? CMD_CREATE :
          (w < 80) ? CMD_READ : (w < 90) ? CMD_SET_TICKETS : (w < 96) ? CMD_REMOVE :
          3'($urandom_range(6, 7));
      s = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
      pp = ($urandom_range(0, 1) == 0) ? 16'd0 : pick_pid();
      w = $urandom_range(0, 9);
      tk = (w == 0) ? 16'd0 : (w < 3) ? 16'($urandom) : 16'($urandom_range(1, 20));
      w = $urandom_range(0, 9);
      ns = (w < 4) ? SS_RUNNABLE : (w < 7) ? SS_SLEEPING : 3'($urandom);
      issue_cmd(c, s, pick_pid(), pp, tk, ns);
    end
    burst = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_state[i] = '0;
      tbl_in_use[i] = '0;
      tbl_pid[i] = '0;
      tbl_tickets[i] = '0;
      tbl_runs[i] = '0;
      tbl_boosts[i] = '0;
    end
    lcg_state = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_create_and_read();
    test_tickets_and_state();
    write_seed(31'h7fffffff);
    test_draw_and_remove();
    write_seed(31'd0);
    test_random_mix(260);
    write_seed(31'($urandom));
    test_random_mix(260);
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

/* files.f */
+incdir+hdl
hdl/lsb_pkg.sv
hdl/lsb_div.sv
hdl/lsb_dp.sv
hdl/lsb_ctrl.sv
hdl/lottery_scheduler_with_boosts.sv
tb/sv/testbench.sv
